// ===== src/skvt_pkg.sv =====
// Package for the sorted key/value table: request codes, transaction
// payload structs and the per-cell control struct. No dependencies.
package skvt_pkg;

  localparam int unsigned KeyFieldBits   = 32;
  localparam int unsigned ValueFieldBits = 32;
  localparam int unsigned CountFieldBits = 5;

  typedef enum logic [1:0] {
    REQ_FIND    = 2'd0,
    REQ_SET     = 2'd1,
    REQ_REPLACE = 2'd2,
    REQ_REMOVE  = 2'd3
  } req_type_e;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_e;

  typedef struct packed {
    req_type_e                 req_type;
    logic [KeyFieldBits-1:0]   key;
    logic [ValueFieldBits-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic                      success;
    logic [ValueFieldBits-1:0] read_value;
    logic [CountFieldBits-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
    logic wr;
  } cell_ctl_t;

endpackage

// ===== src/skvt_cell.sv =====
// One slot of the sorted table: key, value and the compare flags of the
// current request. Depends on skvt_pkg; chained to its neighbors by the top.
module skvt_cell import skvt_pkg::*; #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  occ_i,
  input  cell_ctl_t             ctl_i,
  input  logic [KEY_BITS-1:0]   cmp_key_i,
  input  logic [KEY_BITS-1:0]   new_key_i,
  input  logic [VALUE_BITS-1:0] new_val_i,
  input  logic                  prev_lb_i,
  input  logic [KEY_BITS-1:0]   prev_key_i,
  input  logic [VALUE_BITS-1:0] prev_val_i,
  input  logic [KEY_BITS-1:0]   next_key_i,
  input  logic [VALUE_BITS-1:0] next_val_i,
  output logic                  lb_o,
  output logic                  eq_o,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] val_o
);

  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  lb_q, lb_d;
  logic                  eq_q, eq_d;

  always_comb begin
    lb_d  = lb_q;
    eq_d  = eq_q;
    key_d = key_q;
    val_d = val_q;
    if (ctl_i.cmp) begin
      lb_d = !occ_i || (key_q >= cmp_key_i);
      eq_d = occ_i && (key_q == cmp_key_i);
    end
    if (ctl_i.ins) begin
      if (prev_lb_i) begin
        key_d = prev_key_i;
        val_d = prev_val_i;
      end else if (lb_q) begin
        key_d = new_key_i;
        val_d = new_val_i;
      end
    end else if (ctl_i.rem) begin
      if (lb_q) begin
        key_d = next_key_i;
        val_d = next_val_i;
      end
    end else if (ctl_i.wr) begin
      if (eq_q) begin
        val_d = new_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lb_q  <= lb_d;
    eq_q  <= eq_d;
    key_q <= key_d;
    val_q <= val_d;
  end

  assign lb_o  = lb_q;
  assign eq_o  = eq_q;
  assign key_o = key_q;
  assign val_o = val_q;

endmodule

// ===== src/sorted_key_value_table_unit.sv =====
// Top level of the sorted key/value table: request FSM, entry count, the
// row of skvt_cell slots and the result register. Depends on skvt_pkg, skvt_cell.
//
// The edge that accepts the input transaction latches a compare flag pair
// in every cell (key not below the request key or slot empty, key equal);
// when the apply step fires, all cells shift, write or hold together from
// those flags and the result register loads. That apply step waits while the
// result register still holds a result that has not been taken, and a new
// request is accepted once the apply step is done. Entries are kept in slots
// 0 to count-1 in ascending unsigned key order; no clearing pass is needed
// after reset, the table starts empty.
module sorted_key_value_table_unit import skvt_pkg::*; #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam int unsigned CntBits = $clog2(CAPACITY + 1);

  state_e               state_q, state_d;
  req_t                 req_q;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 out_q, out_d;

  logic                 in_fire, apply_fire, hit, full;
  cell_ctl_t            ctl;
  logic [KEY_BITS-1:0]  cmp_key, new_key;
  logic [VALUE_BITS-1:0] new_val;
  logic [ValueFieldBits-1:0] rd_value;

  logic [CAPACITY-1:0]   lb, eq, occ;
  logic [KEY_BITS-1:0]   cell_key [CAPACITY];
  logic [VALUE_BITS-1:0] cell_val [CAPACITY];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign apply_fire = (state_q == ST_APPLY) && (!out_valid_q || out_ready_i);

  assign cmp_key = KEY_BITS'(in_data_i.key);
  assign new_key = KEY_BITS'(req_q.key);
  assign new_val = VALUE_BITS'(req_q.new_value);
  assign hit     = |eq;
  assign full    = (cnt_q == CntBits'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  prev_lb;
    logic [KEY_BITS-1:0]   prev_key, next_key;
    logic [VALUE_BITS-1:0] prev_val, next_val;

    assign occ[i] = (CntBits'(i) < cnt_q);

    if (i == 0) begin : g_first
      assign prev_lb  = 1'b0;
      assign prev_key = cell_key[i];
      assign prev_val = cell_val[i];
    end else begin : g_prev
      assign prev_lb  = lb[i-1];
      assign prev_key = cell_key[i-1];
      assign prev_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_key = cell_key[i];
      assign next_val = cell_val[i];
    end else begin : g_next
      assign next_key = cell_key[i+1];
      assign next_val = cell_val[i+1];
    end

    skvt_cell #(
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .occ_i     (occ[i]),
      .ctl_i     (ctl),
      .cmp_key_i (cmp_key),
      .new_key_i (new_key),
      .new_val_i (new_val),
      .prev_lb_i (prev_lb),
      .prev_key_i(prev_key),
      .prev_val_i(prev_val),
      .next_key_i(next_key),
      .next_val_i(next_val),
      .lb_o      (lb[i]),
      .eq_o      (eq[i]),
      .key_o     (cell_key[i]),
      .val_o     (cell_val[i])
    );
  end

  always_comb begin
    rd_value = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (eq[i]) begin
        rd_value = rd_value | ValueFieldBits'(cell_val[i]);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ctl         = '0;
    ctl.cmp     = in_fire;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (apply_fire) begin
          out_d.success    = 1'b0;
          out_d.read_value = '0;
          case (req_q.req_type)
            REQ_FIND: begin
              out_d.success = hit;
              if (hit) begin
                out_d.read_value = rd_value;
              end
            end
            REQ_SET: begin
              if (hit) begin
                ctl.wr        = 1'b1;
                out_d.success = 1'b1;
              end else if (!full) begin
                ctl.ins       = 1'b1;
                cnt_d         = cnt_q + CntBits'(1);
                out_d.success = 1'b1;
              end
            end
            REQ_REPLACE: begin
              if (hit) begin
                ctl.wr        = 1'b1;
                out_d.success = 1'b1;
              end
            end
            REQ_REMOVE: begin
              if (hit) begin
                ctl.rem       = 1'b1;
                cnt_d         = cnt_q - CntBits'(1);
                out_d.success = 1'b1;
              end
            end
            default: begin
              out_d.success = 1'b0;
            end
          endcase
          out_d.entry_count = CountFieldBits'(cnt_d);
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_data_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sim/sorted_key_value_table_unit_tb.sv =====
// Self-checking testbench for sorted_key_value_table_unit: an ordered-table predictor,
// valid/ready drivers with random idling and a per-result field checker.
// Depends on skvt_pkg and the sorted_key_value_table_unit RTL.
module sorted_key_value_table_unit_tb;
  import skvt_pkg::*;

  localparam int unsigned TableDepth    = 16;
  localparam int unsigned KeyPoolSize   = 20;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned LongHoldOff   = 80;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;

  logic [KeyFieldBits-1:0]   tbl_key [TableDepth];
  logic [ValueFieldBits-1:0] tbl_val [TableDepth];
  int unsigned               tbl_count;
  logic [KeyFieldBits-1:0]   key_pool [KeyPoolSize];

  rsp_t        expected_rsp_q [$];
  int unsigned error_count;
  int unsigned idle_cycles;
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned rx_hold_cycles;
  int unsigned rx_stall;
  rsp_t        rx_got;
  rsp_t        rx_exp;

  sorted_key_value_table_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic rsp_t apply_table_request(req_t req);
    int unsigned pos;
    int unsigned i;
    bit          hit;
    rsp_t        rsp;
    rsp = '0;
    pos = 0;
    while (pos < tbl_count && tbl_key[pos] < req.key) pos++;
    hit = (pos < tbl_count) && (tbl_key[pos] == req.key);
    case (req.req_type)
      REQ_FIND: begin
        if (hit) begin
          rsp.success    = 1'b1;
          rsp.read_value = tbl_val[pos];
        end
      end
      REQ_SET: begin
        if (hit) begin
          tbl_val[pos] = req.new_value;
          rsp.success  = 1'b1;
        end else if (tbl_count < TableDepth) begin
          for (i = tbl_count; i > pos; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_val[i] = tbl_val[i-1];
          end
          tbl_key[pos] = req.key;
          tbl_val[pos] = req.new_value;
          tbl_count++;
          rsp.success  = 1'b1;
        end
      end
      REQ_REPLACE: begin
        if (hit) begin
          tbl_val[pos] = req.new_value;
          rsp.success  = 1'b1;
        end
      end
      default: begin
        if (hit) begin
          for (i = pos; i + 1 < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_val[i] = tbl_val[i+1];
          end
          tbl_count--;
          rsp.success = 1'b1;
        end
      end
    endcase
    rsp.entry_count = CountFieldBits'(tbl_count);
    return rsp;
  endfunction

  function automatic logic [KeyFieldBits-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) begin
      return key_pool[$urandom_range(0, KeyPoolSize - 1)];
    end
    return $urandom;
  endfunction

  function automatic req_type_e pick_op(int unsigned find_pct, int unsigned set_pct,
                                        int unsigned repl_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < find_pct) return REQ_FIND;
    if (roll < find_pct + set_pct) return REQ_SET;
    if (roll < find_pct + set_pct + repl_pct) return REQ_REPLACE;
    return REQ_REMOVE;
  endfunction

  task automatic send_request(input req_type_e op, input logic [KeyFieldBits-1:0] key,
                              input logic [ValueFieldBits-1:0] value);
    int unsigned gap;
    req_t        req;
    gap           = tx_idle_en ? $urandom_range(0, 3) : 0;
    req.req_type  = op;
    req.key       = key;
    req.new_value = value;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    expected_rsp_q.push_back(apply_table_request(req));
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_and_edges();
    send_request(REQ_FIND,    32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_REMOVE,  32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_REPLACE, 32'hFFFF_FFFF, 32'h1234_5678);
    send_request(REQ_SET,     32'h8000_0000, 32'hA5A5_A5A5);
    send_request(REQ_SET,     32'h7FFF_FFFF, 32'h5A5A_5A5A);
    send_request(REQ_SET,     32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_SET,     32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_FIND,    32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_FIND,    32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_FIND,    32'h8000_0000, 32'hFFFF_FFFF);
    send_request(REQ_FIND,    32'h7FFF_FFFF, 32'h0000_0000);
    send_request(REQ_FIND,    32'h1234_5678, 32'hFFFF_FFFF);
    send_request(REQ_SET,     32'h8000_0000, 32'h0000_0001);
    send_request(REQ_REPLACE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_REPLACE, 32'h0000_0001, 32'hFFFF_FFFF);
    send_request(REQ_REMOVE,  32'h7FFF_FFFE, 32'hFFFF_FFFF);
    send_request(REQ_REMOVE,  32'h0000_0000, 32'h0000_0000);
    send_request(REQ_REMOVE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_FIND,    32'h8000_0000, 32'h0000_0000);
    send_request(REQ_REMOVE,  32'h8000_0000, 32'h0000_0000);
    send_request(REQ_FIND,    32'h8000_0000, 32'hFFFF_FFFF);
    send_request(REQ_REMOVE,  32'h7FFF_FFFF, 32'h0000_0000);
    wait_results_drained();
  endtask

  task automatic test_table_full();
    int unsigned n;
    n = 0;
    while (tbl_count < TableDepth) begin
      send_request(REQ_SET, 32'hF000_0000 - n * 32'd4097, $urandom);
      n++;
    end
    send_request(REQ_SET, 32'h0000_0005, $urandom);
    send_request(REQ_SET, 32'hFFFF_FFFF, $urandom);
    send_request(REQ_SET, tbl_key[0], $urandom);
    send_request(REQ_REPLACE, tbl_key[TableDepth-1], $urandom);
    send_request(REQ_FIND, tbl_key[TableDepth/2], $urandom);
    while (tbl_count > 0) begin
      send_request(REQ_REMOVE, tbl_key[$urandom_range(0, tbl_count - 1)], $urandom);
    end
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    rx_hold_cycles = LongHoldOff;
    tx_idle_en     = 1'b0;
    repeat (20) send_request(pick_op(20, 50, 15), pick_key(), $urandom);
    tx_idle_en     = 1'b1;
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned seg;
    for (seg = 0; seg < 12; seg++) begin
      tx_idle_en = (seg % 4 != 1);
      rx_idle_en = (seg % 4 != 1);
      repeat (45) begin
        case (seg % 3)
          0:       send_request(pick_op(20, 55, 10), pick_key(), $urandom);
          1:       send_request(pick_op(20, 15, 15), pick_key(), $urandom);
          default: send_request(pick_op(25, 25, 25), pick_key(), $urandom);
        endcase
      end
      if (seg % 4 == 3) wait_results_drained();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    wait_results_drained();
  endtask

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      rx_stall = rx_idle_en ? $urandom_range(0, 3) : 0;
      if (rx_hold_cycles > 0) begin
        rx_stall       = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      @(negedge clk_i);
      if (rx_stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      rx_got = out_data_o;
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: result with no request pending: success %b read_value %h count %0d",
                 $time, rx_got.success, rx_got.read_value, rx_got.entry_count);
        error_count++;
      end else begin
        rx_exp = expected_rsp_q.pop_front();
        if (rx_got.success !== rx_exp.success) begin
          $display("%0t: success expected %b actual %b", $time, rx_exp.success,
                   rx_got.success);
          error_count++;
        end
        if (rx_got.read_value !== rx_exp.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, rx_exp.read_value,
                   rx_got.read_value);
          error_count++;
        end
        if (rx_got.entry_count !== rx_exp.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, rx_exp.entry_count,
                   rx_got.entry_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("sorted_key_value_table_unit_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    rst_ni         = 1'b0;
    tbl_count      = 0;
    error_count    = 0;
    idle_cycles    = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    rx_hold_cycles = 0;
    for (int i = 0; i < TableDepth; i++) begin
      tbl_key[i] = '0;
      tbl_val[i] = '0;
    end
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'h8000_0000;
    for (int i = 4; i < KeyPoolSize; i++) key_pool[i] = $urandom;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_and_edges();
    test_table_full();
    test_backpressure();
    test_random_traffic();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("sorted_key_value_table_unit_tb OK");
    end else begin
      $display("sorted_key_value_table_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/skvt_pkg.sv
src/skvt_cell.sv
src/sorted_key_value_table_unit.sv
sim/sorted_key_value_table_unit_tb.sv
